/* src/dnsx_pkg.sv */
package dnsx_pkg;

    // default message length limit in bytes
    localparam int MAX_BYTES_DEFAULT = 512;

    // result queue depth, two slots kept free for a byte that gives two results
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // fixed dns header layout
    localparam logic [15:0] POS_FLAGS_HI = 16'd2;
    localparam logic [15:0] POS_FLAGS_LO = 16'd3;
    localparam logic [15:0] POS_ANCNT_HI = 16'd6;
    localparam logic [15:0] POS_ANCNT_LO = 16'd7;
    localparam logic [15:0] POS_HDR_END  = 16'd11;

    // answer record fixed part
    localparam logic [15:0] FC_TYPE_HI   = 16'd2;
    localparam logic [15:0] FC_TYPE_LO   = 16'd3;
    localparam logic [15:0] FC_RDLEN_HI  = 16'd10;
    localparam logic [15:0] FC_RDLEN_LO  = 16'd11;
    localparam logic [15:0] ANSWER_HDR_LEN = 16'd12;
    localparam logic [15:0] QTAIL_LEN      = 16'd4;

    localparam logic [7:0]  TYPE_A_LO   = 8'h01;
    localparam logic [15:0] IPV4_LEN    = 16'd4;

    typedef enum logic [1:0] {
        KIND_ADDRESS      = 2'd0,
        KIND_NOT_RESPONSE = 2'd1,
        KIND_SERVER_ERROR = 2'd2,
        KIND_END          = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_QNAME  = 6'b000010,
        PH_QTAIL  = 6'b000100,
        PH_ANSWER = 6'b001000,
        PH_RDATA  = 6'b010000,
        PH_IGNORE = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [15:0] answer_index;
        logic        final_answer;
        logic        authoritative;
        logic [3:0]  response_code;
        logic        last;
    } result_t;

endpackage

/* src/dnsx_res_fifo.sv */
module dnsx_res_fifo
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          push_count,
    input  dnsx_pkg::result_t                   push_first,
    input  dnsx_pkg::result_t                   push_second,
    input  logic                                pop,
    output logic                                room,
    output logic                                head_valid,
    output dnsx_pkg::result_t                   head
);

    dnsx_pkg::result_t                   mem_reg [dnsx_pkg::RES_DEPTH];
    logic [dnsx_pkg::RES_PTR_W-1:0]      wr_ptr_reg;
    logic [dnsx_pkg::RES_PTR_W-1:0]      wr_ptr_next;
    logic [dnsx_pkg::RES_PTR_W-1:0]      wr_ptr_second;
    logic [dnsx_pkg::RES_PTR_W-1:0]      rd_ptr_reg;
    logic [dnsx_pkg::RES_PTR_W-1:0]      rd_ptr_next;
    logic [dnsx_pkg::RES_CNT_W-1:0]      count_reg;
    logic [dnsx_pkg::RES_CNT_W-1:0]      count_next;

    assign wr_ptr_second = wr_ptr_reg + dnsx_pkg::RES_PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + dnsx_pkg::RES_PTR_W'(push_count);
    assign rd_ptr_next   = rd_ptr_reg + dnsx_pkg::RES_PTR_W'(pop);
    assign count_next    = count_reg + dnsx_pkg::RES_CNT_W'(push_count)
                           - dnsx_pkg::RES_CNT_W'(pop);

    // at most two in, so keep two slots free before taking a byte
    assign room       = (count_reg <= dnsx_pkg::RES_CNT_W'(dnsx_pkg::RES_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/dnsx_parser.sv */
module dnsx_parser
#(
    parameter int MAX_BYTES = dnsx_pkg::MAX_BYTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_message,
    output logic [1:0]          push_count,
    output dnsx_pkg::result_t   push_first,
    output dnsx_pkg::result_t   push_second
);

    localparam logic [15:0] MaxPos = 16'(MAX_BYTES);

    dnsx_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       pos_reg, pos_next;
    logic [15:0]       fc_reg, fc_next, fc_inc;
    logic              qr_reg, qr_next;
    logic              aa_reg, aa_next;
    logic [3:0]        rcode_reg, rcode_next;
    logic [15:0]       total_reg, total_next;
    logic [15:0]       an_reg, an_next, an_inc;
    logic              type_hi_zero_reg, type_hi_zero_next;
    logic              type_lo_one_reg, type_lo_one_next;
    logic [15:0]       dlen_reg, dlen_next;
    logic [23:0]       shift_reg, shift_next;
    logic              aa_cur;
    logic [3:0]        rcode_cur;
    logic              ev_valid;
    dnsx_pkg::kind_t   ev_kind;
    logic [31:0]       ev_address;
    logic              ev_final;
    dnsx_pkg::result_t ev_res;
    dnsx_pkg::result_t end_res;

    assign fc_inc = fc_reg + 16'd1;
    assign an_inc = an_reg + 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        fc_next           = fc_reg;
        qr_next           = qr_reg;
        aa_next           = aa_reg;
        rcode_next        = rcode_reg;
        total_next        = total_reg;
        an_next           = an_reg;
        type_hi_zero_next = type_hi_zero_reg;
        type_lo_one_next  = type_lo_one_reg;
        dlen_next         = dlen_reg;
        shift_next        = shift_reg;
        ev_valid          = 1'b0;
        ev_kind           = dnsx_pkg::KIND_ADDRESS;
        ev_address        = '0;
        ev_final          = 1'b0;

        if (accept && (pos_reg < MaxPos))
        begin
            pos_next = pos_reg + 16'd1;
            unique case (phase_reg)
                dnsx_pkg::PH_HEADER:
                begin
                    if (pos_reg == dnsx_pkg::POS_FLAGS_HI)
                    begin
                        qr_next = data_byte[7];
                        aa_next = data_byte[2];
                    end
                    if (pos_reg == dnsx_pkg::POS_FLAGS_LO)
                    begin
                        rcode_next = data_byte[3:0];
                    end
                    if (pos_reg == dnsx_pkg::POS_ANCNT_HI)
                    begin
                        total_next[15:8] = data_byte;
                    end
                    if (pos_reg == dnsx_pkg::POS_ANCNT_LO)
                    begin
                        total_next[7:0] = data_byte;
                    end
                    if (pos_reg == dnsx_pkg::POS_HDR_END)
                    begin
                        priority if (!qr_reg)
                        begin
                            ev_valid   = 1'b1;
                            ev_kind    = dnsx_pkg::KIND_NOT_RESPONSE;
                            phase_next = dnsx_pkg::PH_IGNORE;
                        end
                        else if (rcode_reg != 4'd0)
                        begin
                            ev_valid   = 1'b1;
                            ev_kind    = dnsx_pkg::KIND_SERVER_ERROR;
                            phase_next = dnsx_pkg::PH_IGNORE;
                        end
                        else
                        begin
                            phase_next = dnsx_pkg::PH_QNAME;
                        end
                    end
                end
                dnsx_pkg::PH_QNAME:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = dnsx_pkg::PH_QTAIL;
                        fc_next    = '0;
                    end
                end
                dnsx_pkg::PH_QTAIL:
                begin
                    fc_next = fc_inc;
                    if (fc_inc >= dnsx_pkg::QTAIL_LEN)
                    begin
                        fc_next    = '0;
                        an_next    = '0;
                        phase_next = (total_reg == 16'd0) ? dnsx_pkg::PH_IGNORE
                                                          : dnsx_pkg::PH_ANSWER;
                    end
                end
                dnsx_pkg::PH_ANSWER:
                begin
                    if (fc_reg == dnsx_pkg::FC_TYPE_HI)
                    begin
                        type_hi_zero_next = (data_byte == 8'd0);
                    end
                    if (fc_reg == dnsx_pkg::FC_TYPE_LO)
                    begin
                        type_lo_one_next = (data_byte == dnsx_pkg::TYPE_A_LO);
                    end
                    if (fc_reg == dnsx_pkg::FC_RDLEN_HI)
                    begin
                        dlen_next[15:8] = data_byte;
                    end
                    if (fc_reg == dnsx_pkg::FC_RDLEN_LO)
                    begin
                        dlen_next[7:0] = data_byte;
                    end
                    fc_next = fc_inc;
                    if (fc_inc >= dnsx_pkg::ANSWER_HDR_LEN)
                    begin
                        fc_next    = '0;
                        shift_next = '0;
                        if (dlen_next == 16'd0)
                        begin
                            an_next    = an_inc;
                            phase_next = (an_inc == total_reg) ? dnsx_pkg::PH_IGNORE
                                                               : dnsx_pkg::PH_ANSWER;
                        end
                        else
                        begin
                            phase_next = dnsx_pkg::PH_RDATA;
                        end
                    end
                end
                dnsx_pkg::PH_RDATA:
                begin
                    shift_next = {shift_reg[15:0], data_byte};
                    fc_next    = fc_inc;
                    if (fc_inc >= dlen_reg)
                    begin
                        if (type_hi_zero_reg && type_lo_one_reg
                            && (dlen_reg == dnsx_pkg::IPV4_LEN))
                        begin
                            ev_valid   = 1'b1;
                            ev_kind    = dnsx_pkg::KIND_ADDRESS;
                            ev_address = {shift_reg, data_byte};
                            ev_final   = (an_inc == total_reg);
                        end
                        fc_next    = '0;
                        an_next    = an_inc;
                        phase_next = (an_inc == total_reg) ? dnsx_pkg::PH_IGNORE
                                                           : dnsx_pkg::PH_ANSWER;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // header bits including this byte, before any clear
        aa_cur    = aa_next;
        rcode_cur = rcode_next;

        // end of message clears the phase, position, header flags and counts
        if (accept && end_of_message)
        begin
            phase_next = dnsx_pkg::PH_HEADER;
            pos_next   = '0;
            fc_next    = '0;
            qr_next    = 1'b0;
            aa_next    = 1'b0;
            rcode_next = '0;
            total_next = '0;
            an_next    = '0;
        end
    end

    always_comb
    begin
        ev_res.kind          = ev_kind;
        ev_res.address       = ev_address;
        ev_res.answer_index  = (ev_kind == dnsx_pkg::KIND_ADDRESS) ? an_reg : 16'd0;
        ev_res.final_answer  = ev_final;
        ev_res.authoritative = aa_cur;
        ev_res.response_code = rcode_cur;
        ev_res.last          = !end_of_message;

        // flags as they stood before the clear
        end_res.kind          = dnsx_pkg::KIND_END;
        end_res.address       = '0;
        end_res.answer_index  = '0;
        end_res.final_answer  = 1'b0;
        end_res.authoritative = aa_cur;
        end_res.response_code = rcode_cur;
        end_res.last          = 1'b1;

        push_first  = ev_res;
        push_second = end_res;
        push_count  = 2'd0;
        if (accept)
        begin
            priority if (ev_valid && end_of_message)
            begin
                push_count = 2'd2;
            end
            else if (ev_valid)
            begin
                push_count = 2'd1;
            end
            else if (end_of_message)
            begin
                push_count = 2'd1;
                push_first = end_res;
            end
            else
            begin
                push_count = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dnsx_pkg::PH_HEADER;
            pos_reg   <= '0;
            fc_reg    <= '0;
            qr_reg    <= 1'b0;
            aa_reg    <= 1'b0;
            rcode_reg <= '0;
            total_reg <= '0;
            an_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            fc_reg    <= fc_next;
            qr_reg    <= qr_next;
            aa_reg    <= aa_next;
            rcode_reg <= rcode_next;
            total_reg <= total_next;
            an_reg    <= an_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_hi_zero_reg <= type_hi_zero_next;
        type_lo_one_reg  <= type_lo_one_next;
        dlen_reg         <= dlen_next;
        shift_reg        <= shift_next;
    end

endmodule

/* src/dns_response_address_extractor.sv */
// dns response address extractor
//
// input channel: data_byte and end_of_message, one message byte per transfer,
// handshake data_valid / data_stall. end_of_message marks the final byte.
// output channel: one result per transfer (kind, address, answer_index,
// final_answer, authoritative, response_code, last), handshake
// result_valid / result_stall. a byte gives zero, one or two results; last
// flags the final result of that byte
// a byte's results enter the buffer at the clock edge that takes the byte
// throughput: one byte per cycle while data_stall is low; the header,
// question and answer walk is a single state update per byte, and results
// queue in a four-entry buffer
// data_stall rises only while fewer than two buffer slots are free, which is
// set by the receiver draining the buffer, not by the parse
// a stalled receiver holds the head result steady; bytes keep flowing until the
// buffer fills
// reset (rst_n low, asynchronous) empties the buffer and returns the parser to
// the start of a message with header flags and counts cleared
// end_of_message always gives an end result after any other result of that byte
// and clears the message state; bytes past MAX_BYTES are ignored except for it
module dns_response_address_extractor
#(
    parameter int MAX_BYTES = dnsx_pkg::MAX_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [31:0] address,
    output logic [15:0] answer_index,
    output logic        final_answer,
    output logic        authoritative,
    output logic [3:0]  response_code,
    output logic        last
);

    logic              room;
    logic              accept;
    logic              pop;
    logic [1:0]        push_count;
    dnsx_pkg::result_t push_first;
    dnsx_pkg::result_t push_second;
    dnsx_pkg::result_t head;

    // stall depends only on buffer fill, never on valid
    assign data_stall = !room;
    assign accept     = data_valid && room;
    assign pop        = result_valid && !result_stall;

    dnsx_parser
    #(
        .MAX_BYTES (MAX_BYTES)
    )
    u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .push_count     (push_count),
        .push_first     (push_first),
        .push_second    (push_second)
    );

    // result buffer parts the two sides
    dnsx_res_fifo u_res_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (push_first),
        .push_second (push_second),
        .pop         (pop),
        .room        (room),
        .head_valid  (result_valid),
        .head        (head)
    );

    assign kind          = head.kind;
    assign address       = head.address;
    assign answer_index  = head.answer_index;
    assign final_answer  = head.final_answer;
    assign authoritative = head.authoritative;
    assign response_code = head.response_code;
    assign last          = head.last;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    // run shape
    localparam int MSG_LIMIT       = dnsx_pkg::MAX_BYTES_DEFAULT;
    localparam int ITEM_TARGET     = 1650;
    localparam int LONG_MESSAGE_AT = 5;
    localparam int LONG_RECORDS    = 36;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIRECTED      = 49;

    // one row of the directed table; want_* only used where typed is set
    typedef struct packed {
        logic [7:0]      value;
        logic            eom;
        logic            typed;
        dnsx_pkg::kind_t want_kind;
        logic            want_aa;
        logic [3:0]      want_rcode;
    } stim_row_t;

    // short message, then a server error header of all ones, then one answer
    // holding an a record, ending on the last address byte
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h5A, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hA5, 1'b1, 1'b1, dnsx_pkg::KIND_END, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b1, 1'b1, dnsx_pkg::KIND_SERVER_ERROR, 1'b1, 4'hF},
        '{8'h12, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h34, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h85, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h80, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h7F, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hC0, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h0C, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h0E, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h10, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h04, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h00, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'hFF, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h80, 1'b0, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0},
        '{8'h01, 1'b1, 1'b0, dnsx_pkg::KIND_ADDRESS, 1'b0, 4'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        data_valid;
    logic        data_stall;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] answer_index;
    logic        final_answer;
    logic        authoritative;
    logic [3:0]  response_code;
    logic        last;

    // parser state as the predictor sees it
    dnsx_pkg::phase_t parse_phase;
    logic [15:0]      byte_pos;
    logic [15:0]      field_cnt;
    logic [15:0]      hdr_flags;
    logic [15:0]      answers_announced;
    logic [15:0]      answer_no;
    logic [15:0]      rec_type;
    logic [15:0]      rdata_len;
    logic [31:0]      addr_acc;

    // pending results, oldest first; per-byte scratch; hand-typed overrides
    dnsx_pkg::result_t expected_results [$];
    dnsx_pkg::result_t byte_results [$];
    dnsx_pkg::result_t typed_results [$];
    logic [7:0]        message_bytes [$];

    // idling mix, changed by the stimulus as the run moves on
    int unsigned send_idle_pct  = 16;
    int unsigned recv_stall_pct = 87;
    bit          hold_request   = 1'b0;

    int unsigned failures           = 0;
    int unsigned results_checked    = 0;
    int unsigned addresses_seen     = 0;
    int unsigned bytes_sent         = 0;
    int unsigned messages_sent      = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned cycle_count        = 0;

    dns_response_address_extractor #(
        .MAX_BYTES(MSG_LIMIT)
    ) uut (
        .*
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // back to the start of a message with everything cleared
    function automatic void clear_message();
        parse_phase       = dnsx_pkg::PH_HEADER;
        byte_pos          = '0;
        field_cnt         = '0;
        hdr_flags         = '0;
        answers_announced = '0;
        answer_no         = '0;
        rec_type          = '0;
        rdata_len         = '0;
        addr_acc          = '0;
    endfunction

    // header bits come from the flags gathered so far
    function automatic dnsx_pkg::result_t form_result(dnsx_pkg::kind_t k, logic [31:0] addr,
                                                      logic [15:0] idx, logic fin);
        dnsx_pkg::result_t r;
        r.kind          = k;
        r.address       = addr;
        r.answer_index  = idx;
        r.final_answer  = fin;
        r.authoritative = hdr_flags[10];
        r.response_code = hdr_flags[3:0];
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic void step_answer();
        answer_no   = answer_no + 16'd1;
        field_cnt   = '0;
        parse_phase = (answer_no == answers_announced) ? dnsx_pkg::PH_IGNORE
                                                       : dnsx_pkg::PH_ANSWER;
    endfunction

    // advances the parser state by one byte and leaves its results in byte_results
    function automatic void predict_byte(logic [7:0] b, logic eom);
        logic [15:0]       pos;
        dnsx_pkg::result_t r;
        byte_results.delete();
        if (byte_pos < MSG_LIMIT)
        begin
            pos      = byte_pos;
            byte_pos = byte_pos + 16'd1;
            case (parse_phase)
                dnsx_pkg::PH_HEADER:
                begin
                    // flags at bytes 2-3, answer count at 6-7, header done at 11
                    if (pos == 16'd2) hdr_flags[15:8] = b;
                    else if (pos == 16'd3) hdr_flags[7:0] = b;
                    else if (pos == 16'd6) answers_announced[15:8] = b;
                    else if (pos == 16'd7) answers_announced[7:0] = b;
                    if (pos == 16'd11)
                    begin
                        if (!hdr_flags[15])
                        begin
                            byte_results.push_back(
                                form_result(dnsx_pkg::KIND_NOT_RESPONSE, '0, '0, 1'b0));
                            parse_phase = dnsx_pkg::PH_IGNORE;
                        end
                        else if (hdr_flags[3:0] != 4'd0)
                        begin
                            byte_results.push_back(
                                form_result(dnsx_pkg::KIND_SERVER_ERROR, '0, '0, 1'b0));
                            parse_phase = dnsx_pkg::PH_IGNORE;
                        end
                        else
                            parse_phase = dnsx_pkg::PH_QNAME;
                    end
                end
                dnsx_pkg::PH_QNAME:
                begin
                    if (b == 8'h00)
                    begin
                        parse_phase = dnsx_pkg::PH_QTAIL;
                        field_cnt   = '0;
                    end
                end
                dnsx_pkg::PH_QTAIL:
                begin
                    field_cnt = field_cnt + 16'd1;
                    if (field_cnt >= 16'd4)
                    begin
                        field_cnt   = '0;
                        answer_no   = '0;
                        parse_phase = (answers_announced == 16'd0) ? dnsx_pkg::PH_IGNORE
                                                                   : dnsx_pkg::PH_ANSWER;
                    end
                end
                dnsx_pkg::PH_ANSWER:
                begin
                    // name pointer, type, class, ttl, data length
                    if (field_cnt == 16'd2) rec_type[15:8] = b;
                    else if (field_cnt == 16'd3) rec_type[7:0] = b;
                    else if (field_cnt == 16'd10) rdata_len[15:8] = b;
                    else if (field_cnt == 16'd11) rdata_len[7:0] = b;
                    field_cnt = field_cnt + 16'd1;
                    if (field_cnt >= 16'd12)
                    begin
                        field_cnt = '0;
                        addr_acc  = '0;
                        if (rdata_len == 16'd0) step_answer();
                        else parse_phase = dnsx_pkg::PH_RDATA;
                    end
                end
                dnsx_pkg::PH_RDATA:
                begin
                    addr_acc  = {addr_acc[23:0], b};
                    field_cnt = field_cnt + 16'd1;
                    if (field_cnt >= rdata_len)
                    begin
                        if (rec_type == 16'h0001 && rdata_len == 16'd4)
                            byte_results.push_back(
                                form_result(dnsx_pkg::KIND_ADDRESS, addr_acc, answer_no,
                                    ({1'b0, answer_no} + 17'd1) == {1'b0, answers_announced}));
                        step_answer();
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (eom)
        begin
            byte_results.push_back(form_result(dnsx_pkg::KIND_END, '0, '0, 1'b0));
            clear_message();
        end
        if (byte_results.size() != 0)
        begin
            r      = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
    endfunction

    // offers one byte and holds it until the transfer; called at a rising edge
    task automatic offer_byte(input logic [7:0] value, input logic eom_mark);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid     <= 1'b1;
        data_byte      <= value;
        end_of_message <= eom_mark;
        while (!taken)
        begin
            // settled mid-cycle, so this is what the next edge will see
            @(negedge clk);
            taken = (data_stall === 1'b0);
            if (taken)
            begin
                predict_byte(value, eom_mark);
                if (typed_results.size() != 0)
                begin
                    foreach (typed_results[k]) expected_results.push_back(typed_results[k]);
                    typed_results.delete();
                end
                else
                    foreach (byte_results[k]) expected_results.push_back(byte_results[k]);
                if (eom_mark) messages_sent++;
            end
            else
                input_stall_cycles++;
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // random message bodies; header QR set and RCODE clear, the callers bend it
    task automatic build_response(input int unsigned records, input logic [15:0] announced,
                                  input bit only_a);
        int unsigned labels;
        int unsigned len;
        int unsigned rdlen;
        logic [15:0] rtype;
        message_bytes.delete();
        repeat (2) message_bytes.push_back(8'($urandom));
        message_bytes.push_back({1'b1, 7'($urandom)});
        message_bytes.push_back({4'($urandom), 4'h0});
        repeat (2) message_bytes.push_back(8'($urandom));
        message_bytes.push_back(announced[15:8]);
        message_bytes.push_back(announced[7:0]);
        repeat (4) message_bytes.push_back(8'($urandom));
        labels = only_a ? 0 : $urandom_range(3);
        repeat (labels)
        begin
            len = $urandom_range(1, 6);
            message_bytes.push_back(8'(len));
            repeat (len) message_bytes.push_back(8'($urandom_range(1, 255)));
        end
        message_bytes.push_back(8'h00);
        repeat (4) message_bytes.push_back(8'($urandom));
        repeat (records)
        begin
            if (only_a || $urandom_range(99) < 65) rtype = 16'h0001;
            else rtype = 16'($urandom);
            if (rtype == 16'h0001 && (only_a || $urandom_range(99) < 85)) rdlen = 4;
            else rdlen = $urandom_range(10);
            repeat (2) message_bytes.push_back(8'($urandom));
            message_bytes.push_back(rtype[15:8]);
            message_bytes.push_back(rtype[7:0]);
            repeat (6) message_bytes.push_back(8'($urandom));
            message_bytes.push_back(8'(rdlen >> 8));
            message_bytes.push_back(8'(rdlen));
            repeat (rdlen) message_bytes.push_back(8'($urandom));
        end
    endtask

    // compares one result transfer against the oldest pending one
    task automatic check_result();
        dnsx_pkg::result_t want;
        results_checked++;
        if (kind == dnsx_pkg::KIND_ADDRESS) addresses_seen++;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transfer: kind %0d address %h", kind, address);
            failures++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, kind);
                failures++;
            end
            if (address !== want.address)
            begin
                $error("address: expected %h, actual %h", want.address, address);
                failures++;
            end
            if (answer_index !== want.answer_index)
            begin
                $error("answer_index: expected %0d, actual %0d", want.answer_index, answer_index);
                failures++;
            end
            if (final_answer !== want.final_answer)
            begin
                $error("final_answer: expected %b, actual %b", want.final_answer, final_answer);
                failures++;
            end
            if (authoritative !== want.authoritative)
            begin
                $error("authoritative: expected %b, actual %b", want.authoritative,
                       authoritative);
                failures++;
            end
            if (response_code !== want.response_code)
            begin
                $error("response_code: expected %h, actual %h", want.response_code,
                       response_code);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %b, actual %b", want.last, last);
                failures++;
            end
        end
    endtask

    // result side: checks mid-cycle, stalls at the edge; a long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
                check_result();
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t         row;
        dnsx_pkg::result_t fixed;
        int unsigned       style;
        int unsigned       records;
        int unsigned       pick;
        int unsigned       cut;
        int                i;
        bit                pressure_done;
        logic [15:0]       announced;
        pressure_done = 1'b0;
        clear_message();
        rst_n          <= 1'b0;
        data_valid     <= 1'b0;
        data_byte      <= 8'h00;
        end_of_message <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows carry their own expectation
        for (i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.typed)
            begin
                fixed               = '0;
                fixed.kind          = row.want_kind;
                fixed.authoritative = row.want_aa;
                fixed.response_code = row.want_rcode;
                fixed.last          = (row.want_kind == dnsx_pkg::KIND_END) || !row.eom;
                typed_results.push_back(fixed);
                if (row.eom && row.want_kind != dnsx_pkg::KIND_END)
                begin
                    fixed.kind = dnsx_pkg::KIND_END;
                    fixed.last = 1'b1;
                    typed_results.push_back(fixed);
                end
            end
            offer_byte(row.value, row.eom);
        end

        // random messages, mostly well-formed so the answer walk gets exercised
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent >= 2 * ITEM_TARGET / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                // sender keeps streaming while the receiver sits on its hands
                if (!pressure_done)
                begin
                    hold_request  = 1'b1;
                    pressure_done = 1'b1;
                end
            end
            else if (bytes_sent >= ITEM_TARGET / 3)
            begin
                send_idle_pct  = 87;
                recv_stall_pct = 16;
            end

            style   = $urandom_range(99);
            records = $urandom_range(4);
            if (messages_sent == LONG_MESSAGE_AT)
                // runs past the length cap, the tail answers must vanish
                build_response(LONG_RECORDS, 16'(LONG_RECORDS), 1'b1);
            else if (style < 55)
            begin
                announced = 16'(records);
                pick      = $urandom_range(9);
                if (pick == 0) announced = 16'(records + 1);
                else if (pick == 1 && records != 0) announced = 16'(records - 1);
                else if (pick == 2) announced = 16'($urandom);
                build_response(records, announced, 1'b0);
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 4)) message_bytes.push_back(8'($urandom));
            end
            else if (style < 65)
            begin
                // truncated somewhere in the middle
                build_response(records, 16'(records), 1'b0);
                cut = $urandom_range(1, message_bytes.size() - 1);
                while (message_bytes.size() > cut) void'(message_bytes.pop_back());
            end
            else if (style < 75)
            begin
                build_response(records, 16'(records), 1'b0);
                message_bytes[2][7] = 1'b0;
            end
            else if (style < 85)
            begin
                build_response(records, 16'(records), 1'b0);
                message_bytes[3][3:0] = 4'($urandom_range(1, 15));
            end
            else
            begin
                message_bytes.delete();
                repeat ($urandom_range(1, 30)) message_bytes.push_back(8'($urandom));
            end

            for (i = 0; i < message_bytes.size(); i++)
                offer_byte(message_bytes[i], i == message_bytes.size() - 1);
        end
        data_valid <= 1'b0;

        // let everything drain, then keep watching to catch strays
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d messages, %0d bytes offered, %0d results checked (%0d addresses)",
                 messages_sent, bytes_sent, results_checked, addresses_seen);
        $display("input held back for %0d cycles, including a %0d cycle receiver hold-off",
                 input_stall_cycles, HOLD_CYCLES);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
